@@ rtl/fiv_pkg.sv @@
// ----------------------------------------------------------------------------
// fiv_pkg
// Shared types, constants and tables for the firmware image verifier.
// ----------------------------------------------------------------------------
package fiv_pkg;

	typedef enum logic [2:0] {
		VER_OK     = 3'd0,
		VER_TRUNC  = 3'd1,
		VER_TYPE   = 3'd2,
		VER_CRC    = 3'd3,
		VER_BOUNDS = 3'd4,
		VER_FS     = 3'd5,
		VER_MD5    = 3'd6
	} verdict_t;

	typedef enum logic {
		TS_RUN,
		TS_FINISH
	} top_state_t;

	typedef enum logic [2:0] {
		MD_FEED,
		MD_PAD80,
		MD_PADZ,
		MD_PADLEN,
		MD_DRAIN
	} md5_state_t;

	typedef struct packed {
		logic ready;
		logic done;
	} md5_stat_t;

	localparam logic [23:0] POS_MAX    = 24'hFFFFFF;
	localparam logic [23:0] HDR_LEN    = 24'd572;
	localparam logic [23:0] MIN_LEN    = 24'd668;
	localparam logic [23:0] CRC_END    = 24'd568;
	localparam logic [23:0] HASH_START = 24'd588;
	localparam logic [31:0] HDR_LEN_W  = 32'd572;
	localparam logic [31:0] LOAD_WORD  = 32'd524;
	localparam logic [31:0] SIG_WORD   = 32'haa550606;
	localparam logic [31:0] CRC_POLY   = 32'hedb88320;
	localparam logic [31:0] PAGE_BYTES = 32'd4096;
	localparam logic [63:0] USED_MIN   = 64'd96;

	// magic string, character 0 in the low byte
	localparam logic [127:0] MAGIC = 128'h3732313038312d302e31564557534b5a;
	localparam logic [31:0] FS_MAGIC = 32'h73717368;

	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;

	localparam logic [31:0] MD5_K [0:63] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_ROT [0:15] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] r;
		unique case (i[5:4])
			2'd0: r = i[3:0];
			2'd1: r = 4'(i[3:0] * 4'd5 + 4'd1);
			2'd2: r = 4'(i[3:0] * 4'd3 + 4'd5);
			default: r = 4'(i[3:0] * 4'd7);
		endcase
		return r;
	endfunction

endpackage

@@ rtl/firmware_image_verifier.sv @@
// ----------------------------------------------------------------------------
// firmware_image_verifier
// Checks an update image streamed one byte per request: header fields,
// header CRC-32, size bounds, file-system superblock and payload MD5.
//
// Input stream: one image byte per request in tdata, tlast on the final byte.
// Output stream: one verdict per image, status and payload size in tdata.
// While the image streams in, one byte is taken every cycle as long as the
// MD5 unit has a free buffer; header fields and the CRC update in the cycle
// the byte is taken, and MD5 compresses a filled 64-byte block while the
// other buffer fills. After tlast the MD5 unit appends padding and length
// (one byte a cycle while a buffer is free) and finishes the last blocks;
// the verdict then loads into the output register when the output register
// is free. No input is taken from tlast until the verdict is loaded.
// A verdict held by a stalled receiver does not block the next image, but
// that image's verdict waits until the held one is taken.
// Reset clears all checks and returns to expecting byte zero of an image;
// after each verdict the block returns to the same state.
// ----------------------------------------------------------------------------
module firmware_image_verifier import fiv_pkg::*; #(
	parameter int MAX_IMAGE_BYTES = 8388608
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [2:0] status, [34:3] image_size
);

	top_state_t  st_q;
	logic [23:0] pos_q;
	logic [31:0] crc_q;
	logic [63:0] fs_q;
	logic        type_ok_q;
	logic [31:0] hcrc_q;
	logic [31:0] hlen_q;
	logic [31:0] size_q;
	logic        fsok_q;
	logic [63:0] used_q;
	logic [7:0]  dig_q [0:15];
	logic        over_q;
	logic        m_valid_q;
	logic [39:0] m_data_q;

	top_state_t   st_d;
	logic         acc;
	logic [7:0]   b;
	logic [63:0]  fs_n;
	logic [31:0]  w;
	logic [23:0]  doff;
	logic         feed;
	logic         emit;
	md5_stat_t    mstat;
	logic [127:0] digest;
	logic [127:0] expect_dig;
	verdict_t     vd;
	logic         bounds_bad;

	assign s_axis_tready = (st_q == TS_RUN) && mstat.ready;
	assign acc  = s_axis_tvalid && s_axis_tready;
	assign b    = s_axis_tdata;
	assign fs_n = {b, fs_q[63:8]};
	assign w    = fs_n[63:32];
	assign doff = pos_q - HDR_LEN;
	assign feed = acc && ((pos_q >= 24'd32 && pos_q < 24'd48) || pos_q >= HASH_START);
	assign emit = (st_q == TS_FINISH) && mstat.done && !m_valid_q;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	fiv_md5 u_md5 (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.feed_byte (b),
		.finish    (acc && s_axis_tlast),
		.clear     (emit),
		.stat      (mstat),
		.digest    (digest)
	);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			expect_dig[8*i +: 8] = dig_q[i];
		end
		bounds_bad = (hlen_q != HDR_LEN_W) || (size_q < PAGE_BYTES)
			|| (size_q > 32'(MAX_IMAGE_BYTES)) || (size_q[11:0] != 12'd0) || over_q
			|| ({9'd0, pos_q} != ({1'b0, size_q} + 33'(HDR_LEN)));
		if (!over_q && pos_q < MIN_LEN) begin
			vd = VER_TRUNC;
		end else if (!type_ok_q) begin
			vd = VER_TYPE;
		end else if (~crc_q != hcrc_q) begin
			vd = VER_CRC;
		end else if (bounds_bad) begin
			vd = VER_BOUNDS;
		end else if (!fsok_q || used_q < USED_MIN || used_q > {32'd0, size_q}) begin
			vd = VER_FS;
		end else if (digest != expect_dig) begin
			vd = VER_MD5;
		end else begin
			vd = VER_OK;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			TS_RUN: begin
				if (acc && s_axis_tlast) st_d = TS_FINISH;
			end
			TS_FINISH: begin
				if (emit) st_d = TS_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= TS_RUN;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= {5'd0, size_q, vd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '1;
			fs_q <= '0;
			type_ok_q <= 1'b1;
			hcrc_q <= '0;
			hlen_q <= '0;
			size_q <= '0;
			fsok_q <= 1'b1;
			used_q <= '0;
			over_q <= 1'b0;
		end else if (emit) begin
			pos_q <= '0;
			crc_q <= '1;
			fs_q <= '0;
			type_ok_q <= 1'b1;
			hcrc_q <= '0;
			hlen_q <= '0;
			size_q <= '0;
			fsok_q <= 1'b1;
			used_q <= '0;
			over_q <= 1'b0;
		end else if (acc) begin
			if (pos_q == POS_MAX) over_q <= 1'b1;
			else pos_q <= pos_q + 24'd1;
			fs_q <= fs_n;
			if (pos_q < CRC_END) crc_q <= crc_byte(crc_q, b);
			if (pos_q < 24'd16) begin
				if (b != MAGIC[8*pos_q[3:0] +: 8]) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd16 || pos_q == 24'd18) begin
				if (b != 8'd48) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd17) begin
				if (b != 8'd1) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd20) begin
				if (b != 8'd3) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd27) begin
				hlen_q <= w;
			end else if (pos_q == 24'd31) begin
				size_q <= w;
			end else if (pos_q >= 24'd32 && pos_q < 24'd36) begin
				if (b != FS_MAGIC[8*pos_q[1:0] +: 8]) fsok_q <= 1'b0;
			end else if (pos_q == 24'd51) begin
				if (w != LOAD_WORD) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd56) begin
				if (w != SIG_WORD) type_ok_q <= 1'b0;
			end else if (pos_q == 24'd571) begin
				hcrc_q <= w;
			end else if (pos_q == 24'd619) begin
				used_q <= fs_n;
			end
		end
	end

	// expected digest bytes 572..587
	always_ff @(posedge clk) begin
		if (acc && pos_q >= HDR_LEN && pos_q < HASH_START) begin
			dig_q[doff[3:0]] <= b;
		end
	end

endmodule

@@ rtl/fiv_md5.sv @@
// ----------------------------------------------------------------------------
// fiv_md5
// Streaming MD5: double-buffered 64-byte blocks, one round per cycle,
// padding and length append on finish.
// ----------------------------------------------------------------------------
module fiv_md5 import fiv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         feed,
	input  logic [7:0]   feed_byte,
	input  logic         finish,
	input  logic         clear,
	output md5_stat_t    stat,
	output logic [127:0] digest
);

	md5_state_t  mst_q;
	logic [60:0] cnt_q;
	logic [60:0] len_q;
	logic [31:0] buf_q [0:31];
	logic [1:0]  full_q;
	logic        ebank_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] h0_q, h1_q, h2_q, h3_q;

	md5_state_t  mst_d;
	logic [1:0]  full_d;
	logic        wr_bank;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [63:0] len_bits;
	logic        run;
	logic [31:0] av, bv, cv, dv, f, t, nb, m;
	logic [63:0] tt;
	logic [3:0]  g;

	assign wr_bank  = cnt_q[6];
	assign len_bits = {len_q, 3'b000};
	assign stat.ready = !full_q[wr_bank];
	assign stat.done  = (mst_q == MD_DRAIN) && (full_q == 2'b00);
	assign digest = {h3_q, h2_q, h1_q, h0_q};

	always_comb begin
		wr_en = 1'b0;
		wr_byte = 8'h00;
		mst_d = mst_q;
		unique case (mst_q)
			MD_FEED: begin
				wr_en = feed;
				wr_byte = feed_byte;
				if (finish) mst_d = MD_PAD80;
			end
			MD_PAD80: begin
				wr_en = stat.ready;
				wr_byte = 8'h80;
				if (wr_en) mst_d = (cnt_q[5:0] == 6'd55) ? MD_PADLEN : MD_PADZ;
			end
			MD_PADZ: begin
				wr_en = stat.ready;
				if (wr_en && cnt_q[5:0] == 6'd55) mst_d = MD_PADLEN;
			end
			MD_PADLEN: begin
				wr_en = stat.ready;
				wr_byte = len_bits[8*cnt_q[2:0] +: 8];
				if (wr_en && cnt_q[5:0] == 6'd63) mst_d = MD_DRAIN;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		if (clear) mst_d = MD_FEED;
	end

	// round datapath
	assign run = full_q[ebank_q];
	assign g = md5_g(rnd_q);
	assign m = buf_q[{ebank_q, g}];

	always_comb begin
		if (rnd_q == 6'd0) begin
			av = h0_q; bv = h1_q; cv = h2_q; dv = h3_q;
		end else begin
			av = a_q; bv = b_q; cv = c_q; dv = d_q;
		end
		case (rnd_q[5:4])
			2'd0: f = (bv & cv) | (~bv & dv);
			2'd1: f = (dv & bv) | (~dv & cv);
			2'd2: f = bv ^ cv ^ dv;
			default: f = cv ^ (bv | ~dv);
		endcase
		t = f + av + MD5_K[rnd_q] + m;
		tt = {t, t} << MD5_ROT[{rnd_q[5:4], rnd_q[1:0]}];
		nb = bv + tt[63:32];
	end

	always_comb begin
		full_d = full_q;
		if (wr_en && cnt_q[5:0] == 6'd63) full_d[wr_bank] = 1'b1;
		if (run && rnd_q == 6'd63) full_d[ebank_q] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q <= MD_FEED;
		end else begin
			mst_q <= mst_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
			full_q <= 2'b00;
			ebank_q <= 1'b0;
			rnd_q <= '0;
			h0_q <= MD5_A0;
			h1_q <= MD5_B0;
			h2_q <= MD5_C0;
			h3_q <= MD5_D0;
		end else if (clear) begin
			cnt_q <= '0;
			len_q <= '0;
			ebank_q <= 1'b0;
			h0_q <= MD5_A0;
			h1_q <= MD5_B0;
			h2_q <= MD5_C0;
			h3_q <= MD5_D0;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + 61'd1;
			end
			if (mst_q == MD_PAD80 && wr_en) begin
				len_q <= cnt_q;
			end
			full_q <= full_d;
			if (run) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					ebank_q <= !ebank_q;
					h0_q <= h0_q + dv;
					h1_q <= h1_q + nb;
					h2_q <= h2_q + bv;
					h3_q <= h3_q + cv;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[{wr_bank, cnt_q[5:2]}][8*cnt_q[1:0] +: 8] <= wr_byte;
		end
		if (run) begin
			a_q <= dv;
			b_q <= nb;
			c_q <= bv;
			d_q <= cv;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full_q[wr_bank])
		else $error("write into a block still being compressed");
	assert property (@(posedge clk) disable iff (!arst_n) !full_q[ebank_q] |-> rnd_q == 6'd0)
		else $error("round counter moved with no block pending");
	assert property (@(posedge clk) disable iff (!arst_n) full_q[!ebank_q] |-> full_q[ebank_q])
		else $error("blocks compressed out of order");

endmodule
